// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mme_pkg.sv =====
// ---------------------------------------------------------------------------
// mme_pkg
// Types, codes and constants shared by the matrix multiply engine.
// ---------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int CFG_W       = 4;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int FRAC_W      = 16;

  localparam logic [DATA_W-1:0] RES_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] RES_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_L = 2'd0,
    OP_LOAD_R = 2'd1,
    OP_MUL    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_ELEM    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_NUM_ROWS  = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_NUM_COLS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_WAIT
  } seq_state_e;

  // one term of a dot product entering the MAC pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max_v);
    logic [CFG_W-1:0] r;
    begin
      if (v == '0) begin
        r = CFG_W'(1);
      end else if (v > max_v) begin
        r = max_v;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

// ===== hdl/mme_store.sv =====
// ---------------------------------------------------------------------------
// mme_store
// One matrix store: synchronous RAM, one write and one read port, read data
// registered. Per-entry valid flags make unwritten entries read as zero.
// ---------------------------------------------------------------------------
module mme_store import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   we_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     waddr_i,
  input  logic [DATA_W-1:0]                      wdata_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     raddr_i,
  output logic signed [DATA_W-1:0]               rdata_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rdata_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hdl/mme_mac.sv =====
// ---------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate pipeline: operand align, 32x32 product, wide exact
// accumulate, then truncate toward zero to Q16.16 and saturate.
// ---------------------------------------------------------------------------
module mme_mac import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  input  logic                     take_i,
  output logic                     done_o,
  output logic [DATA_W-1:0]        result_o
);

  localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
  localparam int Q_W   = ACC_W - FRAC_W;

  mac_ctrl_t                s1_q, s2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     done_q;
  logic signed [ACC_W-1:0]  biased;
  logic [Q_W-1:0]           q;
  logic                     fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q <= ctrl_i;
      s2_q <= s1_q;
      if (s2_q.vld && s2_q.last) begin
        done_q <= 1'b1;
      end else if (take_i) begin
        done_q <= 1'b0;
      end
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (s2_q.vld) begin
      acc_q <= s2_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  // floor after bias gives truncation toward zero
  always_comb begin
    biased   = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
    q        = biased[ACC_W-1:FRAC_W];
    fits     = (&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1]);
    result_o = fits ? q[DATA_W-1:0] : (q[Q_W-1] ? RES_MIN : RES_MAX);
  end

  assign done_o = done_q;

endmodule

// ===== hdl/mme_seq.sv =====
// ---------------------------------------------------------------------------
// mme_seq
// Item sequencer: load decode and store writes, row/col/inner counters that
// drive store reads and the MAC, and the result output register.
// ---------------------------------------------------------------------------
module mme_seq import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [CFG_W-1:0]                   num_rows_i,
  input  logic [CFG_W-1:0]                   inner_dim_i,
  input  logic [CFG_W-1:0]                   num_cols_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic [2:0]                         row_i,
  input  logic [2:0]                         col_i,
  input  logic signed [DATA_W-1:0]           value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [DATA_W-1:0]           result_o,
  output logic [2:0]                         out_row_o,
  output logic [2:0]                         out_col_o,
  output logic [1:0]                         status_o,
  output logic                               last_o,
  output logic                               l_we_o,
  output logic                               r_we_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr_o,
  output logic [DATA_W-1:0]                  wdata_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] l_raddr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] r_raddr_o,
  output mac_ctrl_t                          mac_ctrl_o,
  output logic                               mac_take_o,
  input  logic                               mac_done_i,
  input  logic [DATA_W-1:0]                  mac_result_i,
  output logic                               busy_o
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);

  seq_state_e        state_q, state_d;
  logic [IDX_W-1:0]  r_q, r_d, c_q, c_d, m_q, m_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [2:0]        orow_q, orow_d, ocol_q, ocol_d;
  status_e           stat_q, stat_d;
  logic              last_q, last_d;
  logic              out_free, in_acc, in_range, m_last, row_end, col_end;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == SEQ_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign busy_o     = (state_q != SEQ_IDLE);

  assign in_range = (op_i == OP_LOAD_L) ?
                    ({1'b0, row_i} < num_rows_i)  && ({1'b0, col_i} < inner_dim_i) :
                    ({1'b0, row_i} < inner_dim_i) && ({1'b0, col_i} < num_cols_i);

  assign waddr_o   = ADDR_W'(int'(row_i) * MAX_DIM + int'(col_i));
  assign wdata_o   = value_i;
  assign l_raddr_o = ADDR_W'(int'(r_q) * MAX_DIM + int'(m_q));
  assign r_raddr_o = ADDR_W'(int'(m_q) * MAX_DIM + int'(c_q));

  assign m_last  = (CFG_W'(m_q) + CFG_W'(1)) == inner_dim_i;
  assign row_end = (CFG_W'(r_q) + CFG_W'(1)) == num_rows_i;
  assign col_end = (CFG_W'(c_q) + CFG_W'(1)) == num_cols_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      r_q       <= '0;
      c_q       <= '0;
      m_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      r_q       <= r_d;
      c_q       <= c_d;
      m_q       <= m_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    orow_q <= orow_d;
    ocol_q <= ocol_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    m_d        = m_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    res_d      = res_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    stat_d     = stat_q;
    last_d     = last_q;
    l_we_o     = 1'b0;
    r_we_o     = 1'b0;
    mac_ctrl_o = '0;
    mac_take_o = 1'b0;

    unique case (state_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          unique case (op_i)
            OP_LOAD_L, OP_LOAD_R: begin
              l_we_o    = in_range && (op_i == OP_LOAD_L);
              r_we_o    = in_range && (op_i == OP_LOAD_R);
              out_vld_d = 1'b1;
              res_d     = '0;
              orow_d    = '0;
              ocol_d    = '0;
              stat_d    = in_range ? ST_OK : ST_IGNORED;
              last_d    = 1'b1;
            end
            OP_MUL: begin
              r_d     = '0;
              c_d     = '0;
              m_d     = '0;
              state_d = SEQ_ISSUE;
            end
            default: ;
          endcase
        end
      end
      SEQ_ISSUE: begin
        mac_ctrl_o.vld   = 1'b1;
        mac_ctrl_o.first = (m_q == '0);
        mac_ctrl_o.last  = m_last;
        if (m_last) begin
          m_d     = '0;
          state_d = SEQ_WAIT;
        end else begin
          m_d = m_q + IDX_W'(1);
        end
      end
      SEQ_WAIT: begin
        if (mac_done_i && out_free) begin
          mac_take_o = 1'b1;
          out_vld_d  = 1'b1;
          res_d      = mac_result_i;
          orow_d     = 3'(r_q);
          ocol_d     = 3'(c_q);
          stat_d     = ST_ELEM;
          last_d     = row_end && col_end;
          if (row_end && col_end) begin
            state_d = SEQ_IDLE;
          end else if (col_end) begin
            c_d     = '0;
            r_d     = r_q + IDX_W'(1);
            state_d = SEQ_ISSUE;
          end else begin
            c_d     = c_q + IDX_W'(1);
            state_d = SEQ_ISSUE;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign status_o    = stat_q;
  assign last_o      = last_q;

endmodule

// ===== hdl/matrix_multiply_engine.sv =====
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// Dense Q16.16 matrix product over two on-chip element stores.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   op_i row_i col_i value_i
//   out      out  out_valid_o / out_ready_i result_o out_row_o out_col_o
//                                           status_o last_o
//   cfg      in   cfg_we_i                  cfg_addr_i cfg_wdata_i
//
// Each load gives one item.
// A multiply gives rows*cols items; each issues one store read per inner
// term, then passes through read, multiply and accumulate stages.
// Input is held off while a multiply runs and while an item waits in the
// output register; a new load can enter in the cycle the waiting item leaves.
// Reset clears the stores through per-entry valid flags; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_addr_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic [2:0]               row_i,
  input  logic [2:0]               col_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] result_o,
  output logic [2:0]               out_row_o,
  output logic [2:0]               out_col_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
  localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

  logic [CFG_W-1:0]         rows_q, inner_q, cols_q;
  logic                     l_we, r_we;
  logic [ADDR_W-1:0]        waddr, l_raddr, r_raddr;
  logic [DATA_W-1:0]        wdata, mac_result;
  logic signed [DATA_W-1:0] a_rd, b_rd;
  mac_ctrl_t                mac_ctrl;
  logic                     mac_take, mac_done, seq_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_MAX;
      inner_q <= DIM_MAX;
      cols_q  <= DIM_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NUM_ROWS:  rows_q  <= clamp_dim(cfg_wdata_i, DIM_MAX);
        REG_INNER_DIM: inner_q <= clamp_dim(cfg_wdata_i, DIM_MAX);
        REG_NUM_COLS:  cols_q  <= clamp_dim(cfg_wdata_i, DIM_MAX);
        default: ;
      endcase
    end
  end

  mme_store #(.MAX_DIM(MAX_DIM)) u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (l_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (l_raddr),
    .rdata_o (a_rd)
  );

  mme_store #(.MAX_DIM(MAX_DIM)) u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (r_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (r_raddr),
    .rdata_o (b_rd)
  );

  mme_mac #(.MAX_DIM(MAX_DIM)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (a_rd),
    .b_i      (b_rd),
    .take_i   (mac_take),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_rows_i   (rows_q),
    .inner_dim_i  (inner_q),
    .num_cols_i   (cols_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .l_we_o       (l_we),
    .r_we_o       (r_we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .l_raddr_o    (l_raddr),
    .r_raddr_o    (r_raddr),
    .mac_ctrl_o   (mac_ctrl),
    .mac_take_o   (mac_take),
    .mac_done_i   (mac_done),
    .mac_result_i (mac_result),
    .busy_o       (seq_busy)
  );

  `ASSERT_IMPL(a_ready_only_idle, in_ready_o, !seq_busy, "input ready during multiply")
  `ASSERT_NEXT(a_mul_starts, in_valid_i && in_ready_o && op_i == OP_MUL,
               seq_busy, "multiply not started")
  `ASSERT_IMPL(a_no_issue_over_done, mac_ctrl.vld, !mac_done, "term issued over unread sum")
  `ASSERT_ALWAYS(a_dims_legal,
                 rows_q != '0 && inner_q != '0 && cols_q != '0 &&
                 rows_q <= DIM_MAX && inner_q <= DIM_MAX && cols_q <= DIM_MAX,
                 "dimension register out of range")

endmodule
